[rtl/core/vfc_pkg.sv]
// vfc_pkg: shared types, codes and the face kind function of the voxel face culler
// no dependencies; imported by vfc_addr_unit, vfc_voxel_mem and voxel_face_culler
`timescale 1ns / 1ps

package vfc_pkg;

  localparam int VFC_EDGE_CELLS = 16;
  localparam int COORD_W = 5;
  localparam int VOXEL_W = 3;
  localparam int DIR_W = 3;
  localparam int N_FACES = 6;

  // voxel and surface codes
  localparam logic [VOXEL_W-1:0] VOXEL_AIR            = 3'd0;
  localparam logic [VOXEL_W-1:0] VOXEL_DIRT           = 3'd1;
  localparam logic [VOXEL_W-1:0] VOXEL_GRASS          = 3'd4;
  localparam logic [VOXEL_W-1:0] VOXEL_SNOWGRASS      = 3'd5;
  localparam logic [VOXEL_W-1:0] VOXEL_GRASS_SIDE     = 3'd6;
  localparam logic [VOXEL_W-1:0] VOXEL_SNOWGRASS_SIDE = 3'd7;

  // face directions, plus the cell itself for address generation
  localparam logic [DIR_W-1:0] DIR_TOP    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_FRONT  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_BACK   = 3'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd4;
  localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd5;
  localparam logic [DIR_W-1:0] DIR_SELF   = 3'd7;

  // address unit operations
  localparam logic ADDR_OP_CELL  = 1'b0;
  localparam logic ADDR_OP_NEIGH = 1'b1;

  typedef struct packed {
    logic             op;
    logic [DIR_W-1:0] dir;
  } addr_ctl_t;

  function automatic logic [VOXEL_W-1:0] vfc_face_kind(input logic [VOXEL_W-1:0] own,
                                                       input logic [DIR_W-1:0] dir);
    logic [VOXEL_W-1:0] side;
    logic [VOXEL_W-1:0] kind;
    side = own;
    if (own == VOXEL_GRASS) begin
      side = VOXEL_GRASS_SIDE;
    end else if (own == VOXEL_SNOWGRASS) begin
      side = VOXEL_SNOWGRASS_SIDE;
    end
    case (dir)
      DIR_TOP: kind = own;
      DIR_BOTTOM: begin
        kind = (side == VOXEL_GRASS_SIDE || side == VOXEL_SNOWGRASS_SIDE) ? VOXEL_DIRT : side;
      end
      default: kind = side;
    endcase
    return kind;
  endfunction

endpackage

[rtl/core/vfc_addr_unit.sv]
// vfc_addr_unit: shared address adder of the voxel face culler
// forms the linear cell index from coordinates, or a neighbor index from the base
// depends on vfc_pkg
`timescale 1ns / 1ps

module vfc_addr_unit import vfc_pkg::*; #(
  parameter int EDGE_CELLS = VFC_EDGE_CELLS,
  parameter int ADDR_W = $clog2((EDGE_CELLS + 2) * (EDGE_CELLS + 2) * (EDGE_CELLS + 2))
) (
  input  addr_ctl_t           ctl,
  input  logic [COORD_W-1:0]  x,
  input  logic [COORD_W-1:0]  y,
  input  logic [COORD_W-1:0]  z,
  input  logic [ADDR_W-1:0]   base,
  output logic [ADDR_W-1:0]   addr
);

  localparam int PADDED = EDGE_CELLS + 2;
  localparam int ROW = PADDED;
  localparam int PLANE = PADDED * PADDED;

  logic [ADDR_W-1:0] opnd_a;
  logic [ADDR_W-1:0] opnd_b;
  logic              sub;

  always_comb begin
    opnd_a = base;
    opnd_b = '0;
    sub = 1'b0;
    unique case (ctl.op)
      ADDR_OP_CELL: begin
        opnd_a = ADDR_W'(x) + ADDR_W'(y) * ADDR_W'(ROW);
        opnd_b = ADDR_W'(z) * ADDR_W'(PLANE);
      end
      ADDR_OP_NEIGH: begin
        case (ctl.dir)
          DIR_TOP:    opnd_b = ADDR_W'(ROW);
          DIR_FRONT:  opnd_b = ADDR_W'(PLANE);
          DIR_BACK: begin
            opnd_b = ADDR_W'(PLANE);
            sub = 1'b1;
          end
          DIR_RIGHT:  opnd_b = ADDR_W'(1);
          DIR_LEFT: begin
            opnd_b = ADDR_W'(1);
            sub = 1'b1;
          end
          DIR_BOTTOM: begin
            opnd_b = ADDR_W'(ROW);
            sub = 1'b1;
          end
          default:    opnd_b = '0;
        endcase
      end
      default: begin
        opnd_b = '0;
      end
    endcase
  end

  assign addr = sub ? (opnd_a - opnd_b) : (opnd_a + opnd_b);

endmodule

[rtl/core/vfc_voxel_mem.sv]
// vfc_voxel_mem: single-port voxel store with registered read data
// depends on vfc_pkg
`timescale 1ns / 1ps

module vfc_voxel_mem import vfc_pkg::*; #(
  parameter int DEPTH = (VFC_EDGE_CELLS + 2) * (VFC_EDGE_CELLS + 2) * (VFC_EDGE_CELLS + 2),
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [VOXEL_W-1:0] wdata,
  output logic [VOXEL_W-1:0] rdata
);

  logic [VOXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/voxel_face_culler.sv]
// voxel_face_culler: padded voxel store with face culling toward air neighbors
// steps: write = index, write; rejected = index; mesh = index, read, last, then emit,
//   busy throughout; an air cell ends in read; face strobes registered, one face per cycle
// throughput: one item at a time; a mesh walks the cell and six neighbors through
//   the single memory port and the shared address unit, one read per cycle
// reset: synchronous; a clearing pass writes air to all (EDGE_CELLS+2)^3 entries,
//   5832 entries at the default size, with busy high; the receiver cannot stall
// depends on vfc_pkg, vfc_addr_unit, vfc_voxel_mem
`timescale 1ns / 1ps

module voxel_face_culler import vfc_pkg::*; #(
  parameter int EDGE_CELLS = VFC_EDGE_CELLS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [COORD_W-1:0] cell_x,
  input  logic [COORD_W-1:0] cell_y,
  input  logic [COORD_W-1:0] cell_z,
  input  logic [VOXEL_W-1:0] voxel_type,
  output logic               face_valid,
  output logic [COORD_W-1:0] face_x,
  output logic [COORD_W-1:0] face_y,
  output logic [COORD_W-1:0] face_z,
  output logic [DIR_W-1:0]   face_dir,
  output logic [VOXEL_W-1:0] face_kind,
  output logic               last_face
);

  localparam int PADDED = EDGE_CELLS + 2;
  localparam int DEPTH = PADDED * PADDED * PADDED;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W = 8;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_INDEX = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_LAST  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // read slot 0 is the cell itself, slots 1..6 are the neighbors in face order
  localparam logic [2:0] LAST_SLOT = 3'd6;
  localparam logic [2:0] OWN_SLOT  = 3'd0;

  logic [2:0]          state;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [2:0]          cnt;
  logic                rd_live;
  logic [2:0]          rd_tag;

  // latched item
  logic                func_q;
  logic [COORD_W-1:0]  cx;
  logic [COORD_W-1:0]  cy;
  logic [COORD_W-1:0]  cz;
  logic [VOXEL_W-1:0]  vt_q;

  logic [ADDR_W-1:0]   base;
  logic [VOXEL_W-1:0]  own_q;
  logic [N_FACES-1:0]  mask;
  logic [N_FACES-1:0]  mask_upd;
  logic [N_FACES-1:0]  rest;
  logic [DIR_W-1:0]    emit_dir;

  addr_ctl_t           actl;
  logic [ADDR_W-1:0]   unit_addr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [VOXEL_W-1:0]  mem_wdata;
  logic [VOXEL_W-1:0]  rd_data;

  logic                in_range;
  logic                interior;

  assign busy = (state != S_IDLE);

  // bounds on the latched coordinates
  assign in_range = ({3'b000, cx} < CMP_W'(PADDED)) && ({3'b000, cy} < CMP_W'(PADDED)) &&
                    ({3'b000, cz} < CMP_W'(PADDED));
  assign interior = (cx != '0) && (cy != '0) && (cz != '0) &&
                    ({3'b000, cx} <= CMP_W'(EDGE_CELLS)) &&
                    ({3'b000, cy} <= CMP_W'(EDGE_CELLS)) &&
                    ({3'b000, cz} <= CMP_W'(EDGE_CELLS));

  // address unit control: cell index in the index step, neighbor walk in the read steps
  always_comb begin
    actl.op = ADDR_OP_NEIGH;
    actl.dir = DIR_SELF;
    if (state == S_INDEX) begin
      actl.op = ADDR_OP_CELL;
    end else if (state == S_READ && cnt != OWN_SLOT) begin
      actl.dir = cnt - 3'd1;
    end
  end

  vfc_addr_unit #(
    .EDGE_CELLS (EDGE_CELLS),
    .ADDR_W     (ADDR_W)
  ) u_addr (
    .ctl  (actl),
    .x    (cx),
    .y    (cy),
    .z    (cz),
    .base (base),
    .addr (unit_addr)
  );

  // memory port: clearing pass or item access
  assign mem_we = (state == S_CLEAR) || (state == S_WRITE);
  assign mem_addr = (state == S_CLEAR) ? clr_cnt : unit_addr;
  assign mem_wdata = (state == S_CLEAR) ? VOXEL_AIR : vt_q;

  vfc_voxel_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rd_data)
  );

  // fold returning neighbor data into the air mask
  always_comb begin
    mask_upd = mask;
    for (int i = 0; i < N_FACES; i++) begin
      if (rd_live && rd_tag == 3'(i + 1)) begin
        mask_upd[i] = (rd_data == VOXEL_AIR);
      end
    end
  end

  // lowest pending face goes first
  always_comb begin
    emit_dir = DIR_TOP;
    for (int i = N_FACES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        emit_dir = 3'(i);
      end
    end
    rest = mask & ~(N_FACES'(1) << emit_dir);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      cnt <= '0;
      rd_live <= 1'b0;
      face_valid <= 1'b0;
      mask <= '0;
    end else begin
      face_valid <= (state == S_EMIT);
      rd_live <= (state == S_READ);
      rd_tag <= cnt;
      if (rd_live && rd_tag == OWN_SLOT) begin
        own_q <= rd_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            func_q <= func;
            cx <= cell_x;
            cy <= cell_y;
            cz <= cell_z;
            vt_q <= voxel_type;
            state <= S_INDEX;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_INDEX: begin
          base <= unit_addr;
          mask <= '0;
          cnt <= '0;
          if (!func_q) begin
            state <= in_range ? S_WRITE : S_IDLE;
          end else begin
            state <= interior ? S_READ : S_IDLE;
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_READ: begin
          mask <= mask_upd;
          cnt <= cnt + 3'd1;
          // air cell: nothing to emit, stop the walk
          if (rd_live && rd_tag == OWN_SLOT && rd_data == VOXEL_AIR) begin
            state <= S_IDLE;
          end else if (cnt == LAST_SLOT) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          mask <= mask_upd;
          // fully enclosed cell emits nothing
          state <= (mask_upd == '0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          face_x <= cx;
          face_y <= cy;
          face_z <= cz;
          face_dir <= emit_dir;
          face_kind <= vfc_face_kind(own_q, emit_dir);
          last_face <= (rest == '0);
          mask <= rest;
          state <= (rest == '0) ? S_IDLE : S_EMIT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a face transfer only follows an emit step
  assert property (@(posedge clk) disable iff (rst)
    face_valid |-> ($past(state) == S_EMIT))
    else $error("face strobe without emit step");

  // faces of one cell come back to back until the last one
  assert property (@(posedge clk) disable iff (rst)
    (face_valid && !last_face) |=> face_valid)
    else $error("gap inside a face burst");

  // emitting always has a pending face
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (mask != '0))
    else $error("emit step with empty face mask");

  // faces belong to interior cells only
  assert property (@(posedge clk) disable iff (rst)
    face_valid |-> (face_x != '0 && face_y != '0 && face_z != '0))
    else $error("face reported for a border cell");

endmodule
